### hw/rtl/assert_macros.svh
// assertion macros used by the port level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion disabled while reset is asserted
`define CDRE_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// concurrent assertion that also holds across reset
`define CDRE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

### hw/rtl/cdre_pkg.sv
// types and constants of the clock drift ratio estimator
`timescale 1ns / 1ps
package cdre_pkg;

  typedef struct packed {
    logic [62:0] local_frames;
    logic [62:0] local_time_ns;
    logic [62:0] network_frames;
    logic [62:0] network_time_ns;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        local_rate;
    logic [31:0]        network_rate;
    logic signed [31:0] drift_median;
    logic [31:0]        ratio_median;
    logic               hint_updated;
    logic [31:0]        hint_ratio;
    logic               is_stable;
    logic [62:0]        elapsed_ns;
  } out_item_t;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_LOWER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_UPPER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED    = 3'd5;

  localparam logic [18:0] NOMINAL_RATE_RST     = 19'd48000;
  localparam logic [31:0] RATIO_LOWER_RST      = 32'd1063004406;
  localparam logic [31:0] RATIO_UPPER_RST      = 32'd1084479242;
  localparam logic [30:0] STABLE_THRESHOLD_RST = 31'd131072;
  localparam logic [7:0]  STABLE_NEEDED_RST    = 8'd5;
  localparam logic [31:0] RATIO_ONE            = 32'd1073741824;

  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [31:0] PPM_SCALE  = 32'd1000000;

endpackage

### hw/rtl/cdre_mul.sv
// 64 by 32 bit multiplier, one 32 by 32 partial product per cycle
`timescale 1ns / 1ps
module cdre_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [95:0] prod_o
);

  logic [63:0] a_q;
  logic [31:0] b_q;
  logic [95:0] acc_q, acc_d;
  logic [1:0]  step_q, step_d;
  logic        done_q, done_d;
  logic [31:0] a_sel;
  logic [63:0] pp;

  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    a_sel  = (step_q == 2'd1) ? a_q[31:0] : a_q[63:32];
    pp     = {32'd0, a_sel} * {32'd0, b_q};
    if (step_q == 2'd1) begin
      acc_d  = {32'd0, pp};
      step_d = 2'd2;
    end else if (step_q == 2'd2) begin
      acc_d  = acc_q + {pp, 32'd0};
      step_d = 2'd0;
      done_d = 1'b1;
    end
    if (start_i) begin
      step_d = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### hw/rtl/cdre_divider.sv
// restoring 128 by 64 bit divider, one quotient bit per cycle, saturating
`timescale 1ns / 1ps
module cdre_divider (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] dividend_i,
  input  logic [63:0]  divisor_i,
  output logic         done_o,
  output logic [63:0]  quot_o
);

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [127:0] dvd_q, dvd_d;
  logic [63:0]  dvs_q, dvs_d;
  logic [63:0]  rem_q, rem_d;
  logic [63:0]  quo_q, quo_d;
  logic         sat_q, sat_d;
  logic [63:0]  shifted;
  logic [64:0]  diff;
  logic         take;

  always_comb begin
    shifted = {rem_q[62:0], dvd_q[127]};
    diff    = {rem_q[63], shifted} - {1'b0, dvs_q};
    take    = !diff[64];
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    sat_d   = sat_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = 64'd0;
      quo_d  = 64'd0;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      rem_d = take ? diff[63:0] : shifted;
      sat_d = sat_q | quo_q[63];
      quo_d = {quo_q[62:0], take};
      dvd_d = {dvd_q[126:0], 1'b0};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd127) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? 64'hFFFF_FFFF_FFFF_FFFF : quo_q;

endmodule

### hw/rtl/cdre_median.sv
// median of drift and ratio histories by rank counting over rotating rings
`timescale 1ns / 1ps
module cdre_median #(
  parameter int unsigned TAPS = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [TAPS-1:0][31:0]  drift_hist_i,
  input  logic [TAPS-1:0][31:0]  ratio_hist_i,
  output logic                   done_o,
  output logic [31:0]            drift_med_o,
  output logic [31:0]            ratio_med_o
);

  localparam int unsigned CNT_W = $clog2(TAPS + 1);
  localparam logic [CNT_W-1:0] MID  = CNT_W'(TAPS / 2);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TAPS - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PICK = 2'd1;
  localparam logic [1:0] PH_SCAN = 2'd2;
  localparam logic [1:0] PH_NEXT = 2'd3;

  logic [1:0]            ph_q, ph_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      k_q, k_d, j_q, j_d;
  logic [CNT_W-1:0]      dlt_q, dlt_d, deq_q, deq_d, rlt_q, rlt_d, req_q, req_d;
  logic [TAPS-1:0][31:0] dr_q, dr_d, rr_q, rr_d;
  logic [31:0]           dcand_q, dcand_d, rcand_q, rcand_d;
  logic [31:0]           dmed_q, dmed_d, rmed_q, rmed_d;
  logic [TAPS-1:0][31:0] dr_rot, rr_rot;

  always_comb begin
    dr_rot  = {dr_q[0], dr_q[TAPS-1:1]};
    rr_rot  = {rr_q[0], rr_q[TAPS-1:1]};
    ph_d    = ph_q;
    done_d  = 1'b0;
    k_d     = k_q;
    j_d     = j_q;
    dlt_d   = dlt_q;
    deq_d   = deq_q;
    rlt_d   = rlt_q;
    req_d   = req_q;
    dr_d    = dr_q;
    rr_d    = rr_q;
    dcand_d = dcand_q;
    rcand_d = rcand_q;
    dmed_d  = dmed_q;
    rmed_d  = rmed_q;
    unique case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          dr_d = drift_hist_i;
          rr_d = ratio_hist_i;
          k_d  = '0;
          ph_d = PH_PICK;
        end
      end
      PH_PICK: begin
        dcand_d = dr_q[0];
        rcand_d = rr_q[0];
        dlt_d   = '0;
        deq_d   = '0;
        rlt_d   = '0;
        req_d   = '0;
        j_d     = '0;
        ph_d    = PH_SCAN;
      end
      PH_SCAN: begin
        if ($signed(dr_q[0]) < $signed(dcand_q)) dlt_d = dlt_q + 1'b1;
        if (dr_q[0] == dcand_q) deq_d = deq_q + 1'b1;
        if (rr_q[0] < rcand_q) rlt_d = rlt_q + 1'b1;
        if (rr_q[0] == rcand_q) req_d = req_q + 1'b1;
        dr_d = dr_rot;
        rr_d = rr_rot;
        j_d  = j_q + 1'b1;
        if (j_q == LAST) ph_d = PH_NEXT;
      end
      PH_NEXT: begin
        if (dlt_q <= MID && MID < dlt_q + deq_q) dmed_d = dcand_q;
        if (rlt_q <= MID && MID < rlt_q + req_q) rmed_d = rcand_q;
        dr_d = dr_rot;
        rr_d = rr_rot;
        k_d  = k_q + 1'b1;
        if (k_q == LAST) begin
          ph_d   = PH_IDLE;
          done_d = 1'b1;
        end else begin
          ph_d = PH_PICK;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
      k_q    <= '0;
      j_q    <= '0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
      k_q    <= k_d;
      j_q    <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dlt_q   <= dlt_d;
    deq_q   <= deq_d;
    rlt_q   <= rlt_d;
    req_q   <= req_d;
    dr_q    <= dr_d;
    rr_q    <= rr_d;
    dcand_q <= dcand_d;
    rcand_q <= rcand_d;
    dmed_q  <= dmed_d;
    rmed_q  <= rmed_d;
  end

  assign done_o      = done_q;
  assign drift_med_o = dmed_q;
  assign ratio_med_o = rmed_q;

endmodule

### hw/rtl/clock_drift_ratio_estimator.sv
// top level of the clock drift and ratio estimator
//
//  channel | direction | handshake           | beat
//  in      | input     | in_valid_i/in_stall_o   | in_data_i (cdre_pkg::in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (cdre_pkg::out_item_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a measured beat holds in_stall_o through three multiplies, four divider passes
// and a median pass; the last bit-serial divider pass is skipped when the ratio saturates
// beats that do not measure, or arrive while disabled, leave in_stall_o low
// in_stall_o is high while a beat is in work; a waiting result holds the last step
// reset clears all control state and history counters; no clearing pass
`timescale 1ns / 1ps
module clock_drift_ratio_estimator #(
  parameter int unsigned MEDIAN_TAPS = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cdre_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cdre_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cdre_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  localparam int unsigned SLOT_W = $clog2(MEDIAN_TAPS);
  localparam int unsigned FILL_W = $clog2(MEDIAN_TAPS + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MEDIAN_TAPS - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MEDIAN_TAPS);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_ML_GO  = 5'd1;
  localparam logic [4:0] ST_ML_W   = 5'd2;
  localparam logic [4:0] ST_DL_GO  = 5'd3;
  localparam logic [4:0] ST_DL_W   = 5'd4;
  localparam logic [4:0] ST_MN_GO  = 5'd5;
  localparam logic [4:0] ST_MN_W   = 5'd6;
  localparam logic [4:0] ST_DN_GO  = 5'd7;
  localparam logic [4:0] ST_DN_W   = 5'd8;
  localparam logic [4:0] ST_DP     = 5'd9;
  localparam logic [4:0] ST_MD_GO  = 5'd10;
  localparam logic [4:0] ST_MD_W   = 5'd11;
  localparam logic [4:0] ST_DD_GO  = 5'd12;
  localparam logic [4:0] ST_DD_W   = 5'd13;
  localparam logic [4:0] ST_DR_GO  = 5'd14;
  localparam logic [4:0] ST_DR_W   = 5'd15;
  localparam logic [4:0] ST_HIST   = 5'd16;
  localparam logic [4:0] ST_MED_GO = 5'd17;
  localparam logic [4:0] ST_MED_W  = 5'd18;
  localparam logic [4:0] ST_FIN    = 5'd19;

  logic [4:0] state_q, state_d;

  // configuration
  logic        enable_q;
  logic [18:0] nominal_q;
  logic [31:0] lower_q, upper_q;
  logic [30:0] thresh_q;
  logic [7:0]  needed_q;

  // snapshot and per-beat working values
  logic [62:0] last_lf_q, last_lt_q, last_nf_q, last_nt_q;
  logic [62:0] lmag_q, lmag_d, nmag_q, nmag_d, dlt_q, dlt_d, dnt_q, dnt_d;
  logic        lneg_q, lneg_d, nneg_q, nneg_d;
  logic [63:0] lr_q, lr_d, nr_q, nr_d, dmag_q, dmag_d;
  logic        dneg_q, dneg_d;
  logic [31:0] drift_q, drift_d, ratio_q, ratio_d;

  // history and tracking
  logic [MEDIAN_TAPS-1:0][31:0] dhist_q, rhist_q;
  logic [SLOT_W-1:0] slot_q;
  logic [FILL_W-1:0] fill_q;
  logic [7:0]        run_q, run_d;
  logic              stable_q, stable_d;
  logic [31:0]       last_drift_q, last_drift_d, hint_q, hint_d;

  logic                out_valid_q;
  cdre_pkg::out_item_t out_q;

  // shared units
  logic         mul_start, mul_done;
  logic [63:0]  mul_a;
  logic [31:0]  mul_b;
  logic [95:0]  mul_prod;
  logic         div_start, div_done;
  logic [127:0] div_dvd;
  logic [63:0]  div_dvs;
  logic [63:0]  div_quot;
  logic         med_start, med_done;
  logic [31:0]  med_drift, mid_ratio;

  logic        in_acc, measure, out_free, fin_go, ratio_sat;
  logic [18:0] nominal_eff;
  logic [64:0] rate_sum;
  logic [31:0] dmed, rmed;
  logic        hupd;
  logic [32:0] ch;
  logic [32:0] ch_abs;

  cdre_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  cdre_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  cdre_median #(
    .TAPS (MEDIAN_TAPS)
  ) u_med (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (med_start),
    .drift_hist_i (dhist_q),
    .ratio_hist_i (rhist_q),
    .done_o       (med_done),
    .drift_med_o  (med_drift),
    .ratio_med_o  (mid_ratio)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fin_go      = (state_q == ST_FIN) && out_free;

  assign measure = (last_lt_q != 63'd0) && (last_nt_q != 63'd0) &&
                   (in_data_i.local_time_ns > last_lt_q) &&
                   (in_data_i.network_time_ns > last_nt_q);

  assign nominal_eff = (nominal_q == 19'd0) ? 19'd1 : nominal_q;
  assign ratio_sat   = lneg_q || (lmag_q == 63'd0) || nneg_q || (lr_q == 64'd0);

  assign mul_start = (state_q == ST_ML_GO) || (state_q == ST_MN_GO) ||
                     (state_q == ST_MD_GO);
  assign div_start = (state_q == ST_DL_GO) || (state_q == ST_DN_GO) ||
                     (state_q == ST_DD_GO) || ((state_q == ST_DR_GO) && !ratio_sat);
  assign med_start = (state_q == ST_MED_GO);

  always_comb begin
    mul_a = {1'b0, lmag_q};
    mul_b = cdre_pkg::NS_PER_SEC;
    if (state_q == ST_MN_GO) begin
      mul_a = {1'b0, nmag_q};
    end else if (state_q == ST_MD_GO) begin
      mul_a = dmag_q;
      mul_b = cdre_pkg::PPM_SCALE;
    end
  end

  always_comb begin
    div_dvd = {mul_prod, 32'd0};
    div_dvs = {1'b0, dlt_q};
    unique case (state_q)
      ST_DN_GO: div_dvs = {1'b0, dnt_q};
      ST_DD_GO: begin
        div_dvd = {32'd0, mul_prod};
        div_dvs = {29'd0, nominal_eff, 16'd0};
      end
      ST_DR_GO: begin
        div_dvd = {34'd0, nr_q, 30'd0};
        div_dvs = lr_q;
      end
      default: ;
    endcase
  end

  // finishing step: medians, hint and stability tracking
  always_comb begin
    dmed = (fill_q == FILL_FULL) ? med_drift : drift_q;
    rmed = (fill_q == FILL_FULL) ? mid_ratio : ratio_q;
    hupd = (rmed > lower_q) && (rmed < upper_q);
    hint_d = hupd ? rmed : hint_q;
    ch     = {dmed[31], dmed} - {last_drift_q[31], last_drift_q};
    ch_abs = ch[32] ? (33'd0 - ch) : ch;
    run_d        = run_q;
    stable_d     = stable_q;
    last_drift_d = last_drift_q;
    if (!stable_q) begin
      if (ch_abs < {2'b00, thresh_q}) begin
        if (run_q != 8'hFF) run_d = run_q + 8'd1;
      end else begin
        run_d = 8'd0;
      end
      last_drift_d = dmed;
      if (run_d >= needed_q) stable_d = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    lmag_d   = lmag_q;
    nmag_d   = nmag_q;
    lneg_d   = lneg_q;
    nneg_d   = nneg_q;
    dlt_d    = dlt_q;
    dnt_d    = dnt_q;
    lr_d     = lr_q;
    nr_d     = nr_q;
    dmag_d   = dmag_q;
    dneg_d   = dneg_q;
    drift_d  = drift_q;
    ratio_d  = ratio_q;
    rate_sum = {1'b0, lr_q} + {1'b0, nr_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && enable_q && measure) begin
          lneg_d = in_data_i.local_frames < last_lf_q;
          nneg_d = in_data_i.network_frames < last_nf_q;
          lmag_d = lneg_d ? (last_lf_q - in_data_i.local_frames)
                          : (in_data_i.local_frames - last_lf_q);
          nmag_d = nneg_d ? (last_nf_q - in_data_i.network_frames)
                          : (in_data_i.network_frames - last_nf_q);
          dlt_d  = in_data_i.local_time_ns - last_lt_q;
          dnt_d  = in_data_i.network_time_ns - last_nt_q;
          state_d = ST_ML_GO;
        end
      end
      ST_ML_GO: state_d = ST_ML_W;
      ST_ML_W:  if (mul_done) state_d = ST_DL_GO;
      ST_DL_GO: state_d = ST_DL_W;
      ST_DL_W: begin
        if (div_done) begin
          lr_d    = div_quot;
          state_d = ST_MN_GO;
        end
      end
      ST_MN_GO: state_d = ST_MN_W;
      ST_MN_W:  if (mul_done) state_d = ST_DN_GO;
      ST_DN_GO: state_d = ST_DN_W;
      ST_DN_W: begin
        if (div_done) begin
          nr_d    = div_quot;
          state_d = ST_DP;
        end
      end
      ST_DP: begin
        if (lneg_q == nneg_q) begin
          if (lr_q >= nr_q) begin
            dmag_d = lr_q - nr_q;
            dneg_d = lneg_q;
          end else begin
            dmag_d = nr_q - lr_q;
            dneg_d = !lneg_q;
          end
        end else begin
          dmag_d = rate_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : rate_sum[63:0];
          dneg_d = lneg_q;
        end
        state_d = ST_MD_GO;
      end
      ST_MD_GO: state_d = ST_MD_W;
      ST_MD_W:  if (mul_done) state_d = ST_DD_GO;
      ST_DD_GO: state_d = ST_DD_W;
      ST_DD_W: begin
        if (div_done) begin
          if (dneg_q) begin
            drift_d = (div_quot[63:31] != 33'd0) ? 32'h8000_0000
                                                 : (32'd0 - div_quot[31:0]);
          end else begin
            drift_d = (div_quot[63:31] != 33'd0) ? 32'h7FFF_FFFF : div_quot[31:0];
          end
          state_d = ST_DR_GO;
        end
      end
      ST_DR_GO: begin
        if (ratio_sat) begin
          ratio_d = 32'hFFFF_FFFF;
          state_d = ST_HIST;
        end else begin
          state_d = ST_DR_W;
        end
      end
      ST_DR_W: begin
        if (div_done) begin
          ratio_d = (div_quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quot[31:0];
          state_d = ST_HIST;
        end
      end
      ST_HIST:   state_d = ST_MED_GO;
      ST_MED_GO: state_d = ST_MED_W;
      ST_MED_W:  if (med_done) state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      enable_q     <= 1'b1;
      nominal_q    <= cdre_pkg::NOMINAL_RATE_RST;
      lower_q      <= cdre_pkg::RATIO_LOWER_RST;
      upper_q      <= cdre_pkg::RATIO_UPPER_RST;
      thresh_q     <= cdre_pkg::STABLE_THRESHOLD_RST;
      needed_q     <= cdre_pkg::STABLE_NEEDED_RST;
      last_lf_q    <= 63'd0;
      last_lt_q    <= 63'd0;
      last_nf_q    <= 63'd0;
      last_nt_q    <= 63'd0;
      slot_q       <= '0;
      fill_q       <= '0;
      run_q        <= 8'd0;
      stable_q     <= 1'b0;
      last_drift_q <= 32'd0;
      hint_q       <= cdre_pkg::RATIO_ONE;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          cdre_pkg::REG_REPORT_ENABLE:    enable_q  <= cfg_data_i[0];
          cdre_pkg::REG_NOMINAL_RATE:     nominal_q <= cfg_data_i[18:0];
          cdre_pkg::REG_RATIO_LOWER:      lower_q   <= cfg_data_i;
          cdre_pkg::REG_RATIO_UPPER:      upper_q   <= cfg_data_i;
          cdre_pkg::REG_STABLE_THRESHOLD: thresh_q  <= cfg_data_i[30:0];
          cdre_pkg::REG_STABLE_NEEDED:    needed_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_acc && enable_q) begin
        last_lf_q <= in_data_i.local_frames;
        last_lt_q <= in_data_i.local_time_ns;
        last_nf_q <= in_data_i.network_frames;
        last_nt_q <= in_data_i.network_time_ns;
      end
      if (state_q == ST_HIST) begin
        slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
        if (fill_q != FILL_FULL) fill_q <= fill_q + 1'b1;
      end
      if (fin_go) begin
        run_q        <= run_d;
        stable_q     <= stable_d;
        last_drift_q <= last_drift_d;
        hint_q       <= hint_d;
        out_valid_q  <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lmag_q  <= lmag_d;
    nmag_q  <= nmag_d;
    lneg_q  <= lneg_d;
    nneg_q  <= nneg_d;
    dlt_q   <= dlt_d;
    dnt_q   <= dnt_d;
    lr_q    <= lr_d;
    nr_q    <= nr_d;
    dmag_q  <= dmag_d;
    dneg_q  <= dneg_d;
    drift_q <= drift_d;
    ratio_q <= ratio_d;
    if (state_q == ST_HIST) begin
      dhist_q[slot_q] <= drift_q;
      rhist_q[slot_q] <= ratio_q;
    end
    if (fin_go) begin
      out_q.local_rate   <= lneg_q ? 32'd0 :
                            ((lr_q[63:56] != 8'd0) ? 32'hFFFF_FFFF : lr_q[55:24]);
      out_q.network_rate <= nneg_q ? 32'd0 :
                            ((nr_q[63:56] != 8'd0) ? 32'hFFFF_FFFF : nr_q[55:24]);
      out_q.drift_median <= dmed;
      out_q.ratio_median <= rmed;
      out_q.hint_updated <= hupd;
      out_q.hint_ratio   <= hint_d;
      out_q.is_stable    <= stable_d;
      out_q.elapsed_ns   <= dlt_q;
    end
  end

endmodule

### hw/rtl/cdre_checker.sv
// port level checks of the clock drift ratio estimator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cdre_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input cdre_pkg::in_item_t             in_data_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input cdre_pkg::out_item_t            out_data_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [cdre_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [31:0]                    cfg_data_i
);

  logic in_beat;
  logic cfg_beat;

  assign in_beat  = in_valid_i && !in_stall_o && (in_data_i.local_time_ns != 63'd0 ||
                    in_data_i.local_time_ns == 63'd0);
  assign cfg_beat = cfg_valid_i && cfg_ready_o && (cfg_index_i == cfg_index_i) &&
                    (cfg_data_i == cfg_data_i);

  // held result stays put
  `CDRE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `CDRE_ASSERT(a_out_stable, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> $stable(out_data_o))
  // a new result only comes out of a busy period, which ends as it appears
  `CDRE_ASSERT(a_result_after_busy, clk_i, rst_ni,
    $rose(out_valid_o) |-> $past(in_stall_o) && !in_stall_o)
  // an accepted beat never yields a result in the very next cycle
  `CDRE_ASSERT(a_no_instant_result, clk_i, rst_ni,
    in_beat && !out_valid_o && !cfg_beat |=> !out_valid_o)
  `CDRE_ASSERT_ALWAYS(a_reset_clears, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind clock_drift_ratio_estimator cdre_checker u_cdre_checker (.*);
